@@ rtl/scl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scl_pkg
// Shared widths, codes and types of the sector cache tag and LRU engine.
// ----------------------------------------------------------------------------
package scl_pkg;

	localparam int LINES  = 8;
	localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int ADDR_W = 32;
	localparam int AGE_W  = 32;
	localparam int IDX_W  = 3;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_IOERR = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic [AGE_W-1:0]  age;
	} entry_t;

	typedef struct packed {
		logic              re;
		logic [LINE_W-1:0] raddr;
		logic              we;
		logic [LINE_W-1:0] waddr;
		entry_t            wdata;
	} ram_req_t;

	typedef struct packed {
		logic              clear;
		logic              cmp;
		logic [LINE_W-1:0] idx;
	} scan_ctl_t;

	typedef struct packed {
		logic              hit;
		logic [LINE_W-1:0] hit_idx;
		logic [LINE_W-1:0] victim_idx;
	} scan_res_t;

	// Low field bits of a line number.
	function automatic logic [IDX_W-1:0] line_field(input logic [LINE_W-1:0] idx);
		logic [LINE_W+IDX_W-1:0] ext;
		ext = {{IDX_W{1'b0}}, idx};
		return ext[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/scl_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scl_req_if
// Request channel: command, sector address and device outcome.
// ----------------------------------------------------------------------------
interface scl_req_if import scl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [ADDR_W-1:0] sector_address;
	logic              device_ok;

	modport source (output valid, output command, output sector_address,
		output device_ok, input ready);
	modport sink (input valid, input command, input sector_address,
		input device_ok, output ready);
endinterface
`default_nettype wire

@@ rtl/scl_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scl_rsp_if
// Result channel: status, lookup outcome and line actions.
// ----------------------------------------------------------------------------
interface scl_rsp_if import scl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic             hit;
	logic [IDX_W-1:0] line_index;
	logic             fill_line;
	logic             update_line;
	logic             device_access;

	modport source (output valid, output status, output hit, output line_index,
		output fill_line, output update_line, output device_access, input ready);
	modport sink (input valid, input status, input hit, input line_index,
		input fill_line, input update_line, input device_access, output ready);
endinterface
`default_nettype wire

@@ rtl/scl_tag_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scl_tag_ram
// Tag and age store, one entry per line, registered read port.
// ----------------------------------------------------------------------------
module scl_tag_ram import scl_pkg::*; (
	input  wire logic     clk,
	input  wire ram_req_t req,
	output entry_t        rdata
);
	entry_t mem [LINES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ rtl/scl_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scl_scan
// Per-line tag match and oldest-line tracking over the entries read back.
// ----------------------------------------------------------------------------
module scl_scan import scl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scan_ctl_t         ctl,
	input  wire entry_t            rdata,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [LINES-1:0]  valid,
	output scan_res_t              res
);
	logic              hit_q;
	logic              min_set_q;
	logic [LINE_W-1:0] hit_idx_q;
	logic [LINE_W-1:0] min_idx_q;
	logic [AGE_W-1:0]  min_age_q;
	logic              line_ok;
	logic              take_hit;
	logic              take_min;
	logic              any_inv;
	logic [LINE_W-1:0] inv_idx;

	assign line_ok  = ctl.cmp && valid[ctl.idx];
	assign take_hit = line_ok && !hit_q && (rdata.tag == addr);
	// strict compare keeps the lowest-numbered line among equal ages
	assign take_min = line_ok && (!min_set_q || (rdata.age < min_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			min_set_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q     <= 1'b0;
			min_set_q <= 1'b0;
		end else begin
			if (take_hit) hit_q <= 1'b1;
			if (take_min) min_set_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) hit_idx_q <= ctl.idx;
		if (take_min) begin
			min_idx_q <= ctl.idx;
			min_age_q <= rdata.age;
		end
	end

	always_comb begin
		any_inv = 1'b0;
		inv_idx = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				any_inv = 1'b1;
				inv_idx = LINE_W'(i);
			end
		end
	end

	assign res.hit        = hit_q;
	assign res.hit_idx    = hit_idx_q;
	assign res.victim_idx = any_inv ? inv_idx : min_idx_q;
endmodule
`default_nettype wire

@@ rtl/sector_cache_lru_tags.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sector_cache_lru_tags
// Tag and replacement engine of a fully associative write-through sector
// cache: lookup, oldest-line victim choice, fill and stamp.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | command, sector_address, device_ok
//  rsp     | out | valid/ready | status, hit, line_index, fill_line,
//          |     |             | update_line, device_access
//
// A request goes through these steps in order: the accept, one tag memory
// read per line, a compare of the last entry, and a final step that decides
// and writes back; the result register is loaded in that final step. One
// request is in work at a time; the result register lets the next request
// enter while an earlier result waits. The final step holds
// while that register is still full and not being taken.
// Reset clears the valid bits and the use clock; the tag memory needs no
// clearing pass, since an invalid line is never matched nor aged.
// ----------------------------------------------------------------------------
module sector_cache_lru_tags import scl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	scl_req_if.sink    req,
	scl_rsp_if.source  rsp
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES - 1);

	logic [1:0]        state_q;
	logic [LINE_W-1:0] rd_ptr_q;
	logic              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic              ok_q;
	logic              cmp_vld_s1;
	logic [LINE_W-1:0] cmp_idx_s1;
	logic [LINES-1:0]  valid_q;
	logic [AGE_W-1:0]  use_clock_q;

	logic              rsp_vld_q;
	logic              status_q;
	logic              hit_q;
	logic [IDX_W-1:0]  line_index_q;
	logic              fill_q;
	logic              update_q;
	logic              access_q;

	ram_req_t          ram_req;
	entry_t            ram_rdata;
	scan_ctl_t         scan_ctl;
	scan_res_t         scan_res;

	logic              accept;
	logic              finish;
	logic              is_write;
	logic [LINE_W-1:0] line;
	logic              stamp;
	logic              fill;
	logic              update;
	logic              access;
	logic              status;
	logic [AGE_W-1:0]  next_clock;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign finish    = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);

	// decide from the scan outcome
	always_comb begin
		is_write = (cmd_q == CMD_WRITE);
		fill     = 1'b0;
		update   = 1'b0;
		stamp    = 1'b0;
		access   = 1'b1;
		status   = ST_OK;
		line     = scan_res.hit ? scan_res.hit_idx : '0;
		if (!is_write) begin
			if (scan_res.hit) begin
				stamp  = 1'b1;
				access = 1'b0;
			end else begin
				line = scan_res.victim_idx;
				if (ok_q) begin
					fill  = 1'b1;
					stamp = 1'b1;
				end else begin
					status = ST_IOERR;
				end
			end
		end else begin
			if (!ok_q) begin
				status = ST_IOERR;
			end else if (scan_res.hit) begin
				update = 1'b1;
				stamp  = 1'b1;
			end
		end
	end

	assign next_clock = use_clock_q + AGE_W'(1);

	// writeback only in the final step, never while the scan reads
	assign ram_req.re        = (state_q == ST_SCAN);
	assign ram_req.raddr     = rd_ptr_q;
	assign ram_req.we        = finish && stamp;
	assign ram_req.waddr     = line;
	assign ram_req.wdata.tag = addr_q;
	assign ram_req.wdata.age = next_clock;

	assign scan_ctl.clear = accept;
	assign scan_ctl.cmp   = cmp_vld_s1;
	assign scan_ctl.idx   = cmp_idx_s1;

	scl_tag_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	scl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.rdata  (ram_rdata),
		.addr   (addr_q),
		.valid  (valid_q),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_ptr_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			valid_q     <= '0;
			use_clock_q <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ptr_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_ptr_q <= rd_ptr_q + LINE_W'(1);
					if (rd_ptr_q == LAST_LINE) state_q <= ST_LAST;
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish && stamp) begin
				use_clock_q <= next_clock;
			end
			if (finish && fill) begin
				valid_q[line] <= 1'b1;
			end
			if (finish) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_ptr_q;
		if (accept) begin
			cmd_q  <= req.command;
			addr_q <= req.sector_address;
			ok_q   <= req.device_ok;
		end
		if (finish) begin
			status_q     <= status;
			hit_q        <= scan_res.hit;
			line_index_q <= line_field(line);
			fill_q       <= fill;
			update_q     <= update;
			access_q     <= access;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = status_q;
	assign rsp.hit           = hit_q;
	assign rsp.line_index    = line_index_q;
	assign rsp.fill_line     = fill_q;
	assign rsp.update_line   = update_q;
	assign rsp.device_access = access_q;
endmodule
`default_nettype wire

@@ rtl/scl_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scl_checker
// Port-level checks on the result channel of the sector cache engine.
// ----------------------------------------------------------------------------
module scl_checker import scl_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic             status,
	input wire logic             hit,
	input wire logic [IDX_W-1:0] line_index,
	input wire logic             fill_line,
	input wire logic             update_line,
	input wire logic             device_access
);
	// a fill only follows a successful read miss
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fill_line |-> !hit && (status == ST_OK) && device_access
		&& !update_line)
		else $error("fill without a successful miss");

	// an update only follows a successful write hit
	a_update: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && update_line |-> hit && (status == ST_OK) && device_access)
		else $error("update without a successful write hit");

	// only a read hit skips the device, and it cannot fail
	a_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !device_access |-> hit && (status == ST_OK) && !fill_line
		&& !update_line)
		else $error("device skipped on a request that needs it");

	// hold a pending result until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_index)
		&& $stable(hit) && $stable(status))
		else $error("result dropped or changed while stalled");
endmodule

bind sector_cache_lru_tags scl_checker u_scl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.hit           (rsp.hit),
	.line_index    (rsp.line_index),
	.fill_line     (rsp.fill_line),
	.update_line   (rsp.update_line),
	.device_access (rsp.device_access)
);
`default_nettype wire
